// ===== rtl/lpfd_pkg.sv =====
// Package for the length-prefixed frame deframer.
// Holds the beat types, result kinds and byte constants; no dependencies.
`default_nettype none

package lpfd_pkg;

    localparam int LEN_W = 64;

    localparam logic [7:0] MARKER_BYTE = 8'h00;
    localparam logic [7:0] TERM_BYTE   = 8'hFF;
    localparam logic [7:0] DIGIT_MAX   = 8'd9;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_start;
    } t_in_beat;

    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lpfd_parse.sv =====
// Frame parser: phase, digit count, length and remaining-byte registers.
// Produces at most one result per accepted beat; depends on lpfd_pkg.
`default_nettype none

module lpfd_parse #(
    parameter int MAX_DIGITS = 20
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_take,
    input  lpfd_pkg::t_in_beat    i_in,
    output lpfd_pkg::t_result     o_res
);
    import lpfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        PH_MARKER  = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } t_phase;

    t_phase             r_phase, n_phase, phase_eff;
    logic [CNT_W-1:0]   r_digit_count, n_digit_count;
    logic [LEN_W-1:0]   r_length, n_length;
    logic [LEN_W-1:0]   r_bytes_left, n_bytes_left;
    logic [LEN_W+3:0]   len_x10;
    logic               len_ovf;
    logic [7:0]         b;

    assign b         = i_in.data_byte;
    assign phase_eff = i_in.body_start ? PH_MARKER : r_phase;

    // length * 10 + digit, with carry bits to catch overflow
    assign len_x10 = {1'b0, r_length, 3'b000}
                   + {3'b000, r_length, 1'b0}
                   + {{(LEN_W-4){1'b0}}, b};
    assign len_ovf = |len_x10[LEN_W+3:LEN_W];

    always_comb begin
        n_phase       = phase_eff;
        n_digit_count = r_digit_count;
        n_length      = r_length;
        n_bytes_left  = r_bytes_left;
        o_res         = '0;
        case (phase_eff)
            PH_MARKER: begin
                if (b != MARKER_BYTE) begin
                    n_phase                  = PH_ERROR;
                    o_res.valid              = 1'b1;
                    o_res.beat.result_kind   = KIND_ERROR;
                end else begin
                    n_phase       = PH_DIGITS;
                    n_digit_count = '0;
                    n_length      = '0;
                end
            end
            PH_DIGITS: begin
                if (b == TERM_BYTE) begin
                    if (r_digit_count == '0) begin
                        n_phase                = PH_ERROR;
                        o_res.valid            = 1'b1;
                        o_res.beat.result_kind = KIND_ERROR;
                    end else if (r_length == '0) begin
                        n_phase                  = PH_MARKER;
                        o_res.valid              = 1'b1;
                        o_res.beat.result_kind   = KIND_EMPTY;
                        o_res.beat.last_of_frame = 1'b1;
                    end else begin
                        n_bytes_left = r_length;
                        n_phase      = PH_PAYLOAD;
                    end
                end else if (b > DIGIT_MAX || r_digit_count >= CNT_W'(MAX_DIGITS)
                             || len_ovf) begin
                    n_phase                = PH_ERROR;
                    o_res.valid            = 1'b1;
                    o_res.beat.result_kind = KIND_ERROR;
                end else begin
                    n_length      = len_x10[LEN_W-1:0];
                    n_digit_count = r_digit_count + CNT_W'(1);
                end
            end
            PH_PAYLOAD: begin
                o_res.valid             = 1'b1;
                o_res.beat.result_kind  = KIND_PAYLOAD;
                o_res.beat.payload_byte = b;
                if (r_bytes_left <= LEN_W'(1)) begin
                    o_res.beat.last_of_frame = 1'b1;
                    n_phase                  = PH_MARKER;
                end
                if (r_bytes_left != '0) begin
                    n_bytes_left = r_bytes_left - LEN_W'(1);
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MARKER;
            r_digit_count <= '0;
            r_length      <= '0;
            r_bytes_left  <= '0;
        end else if (i_take) begin
            r_phase       <= n_phase;
            r_digit_count <= n_digit_count;
            r_length      <= n_length;
            r_bytes_left  <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/length_prefix_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
// Wraps lpfd_parse with the input handshake and a result register; uses lpfd_pkg.
//
//  channel | dir | handshake                    | beat
//  --------+-----+------------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_ready      | data_byte, body_start
//  out     | out | o_out_valid / i_out_ready    | result_kind, payload_byte, last
//
// One beat per cycle unless output stalls; each result is registered at accept.
// Parser state updates at input accept; the result register holds one beat.
// Input is taken whenever the result register is empty or being drained.
// Reset (sync, active low) returns to the start-marker phase and drops results.
`default_nettype none

module length_prefix_frame_deframer #(
    parameter int MAX_DIGITS = 20
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  lpfd_pkg::t_in_beat     i_in,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output lpfd_pkg::t_out_beat    o_out
);
    import lpfd_pkg::*;

    logic      take;
    t_result   res;
    logic      r_out_valid;
    t_out_beat r_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lpfd_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res.beat;
        end
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for length_prefix_frame_deframer: directed and random body streams,
// every output beat checked against a behavioral frame parser in a scoreboard class.
// Depends on lpfd_pkg and the deframer RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;

    localparam int MAX_DIGITS = 20;
    localparam int RUN_BEATS  = 1350;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT   = 19;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef enum logic [1:0] {
        PH_MARKER,
        PH_DIGITS,
        PH_PAYLOAD,
        PH_ERROR
    } t_parse_phase;

    class deframer_scoreboard;
        t_out_beat    due_results[$];
        t_parse_phase ph;
        int           ndig;
        logic [63:0]  len_acc;
        logic [63:0]  remaining;
        int           live_beats;
        int           errors;

        function new();
            ph = PH_MARKER;
            ndig = 0;
            len_acc = '0;
            remaining = '0;
            live_beats = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // parse one accepted input beat and queue the result it causes
        function void record_byte(t_in_beat b);
            t_out_beat r;
            bit        has;
            bit        bad;
            r = '0;
            has = 0;
            bad = 0;
            if (b.body_start) begin
                ph = PH_MARKER;
                ndig = 0;
                len_acc = '0;
                remaining = '0;
            end
            live_beats++;
            case (ph)
                PH_MARKER: begin
                    if (b.data_byte != MARKER_BYTE) begin
                        bad = 1;
                    end else begin
                        ph = PH_DIGITS;
                        ndig = 0;
                        len_acc = '0;
                    end
                end
                PH_DIGITS: begin
                    if (b.data_byte == TERM_BYTE) begin
                        if (ndig == 0) begin
                            bad = 1;
                        end else if (len_acc == 0) begin
                            ph = PH_MARKER;
                            has = 1;
                            r.result_kind = KIND_EMPTY;
                            r.last_of_frame = 1'b1;
                        end else begin
                            remaining = len_acc;
                            ph = PH_PAYLOAD;
                        end
                    end else if (b.data_byte > DIGIT_MAX || ndig >= MAX_DIGITS ||
                                 len_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(b.data_byte))
                                           / 64'd10) begin
                        bad = 1;
                    end else begin
                        len_acc = len_acc * 64'd10 + 64'(b.data_byte);
                        ndig++;
                    end
                end
                PH_PAYLOAD: begin
                    has = 1;
                    r.result_kind = KIND_PAYLOAD;
                    r.payload_byte = b.data_byte;
                    r.last_of_frame = (remaining <= 1);
                    if (remaining > 0) remaining--;
                    if (r.last_of_frame) ph = PH_MARKER;
                end
                default: ;
            endcase
            if (bad) begin
                ph = PH_ERROR;
                has = 1;
                r.result_kind = KIND_ERROR;
            end
            if (has) due_results.push_back(r);
        endfunction

        function void compare_result(t_out_beat got);
            t_out_beat exp;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected beat kind %0d byte %0h last %0d", $time,
                         got.result_kind, got.payload_byte, got.last_of_frame);
                errors++;
                return;
            end
            exp = due_results.pop_front();
            if (got.result_kind !== exp.result_kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time,
                         exp.result_kind, got.result_kind);
                errors++;
            end
            if (got.payload_byte !== exp.payload_byte) begin
                $display("%0t: payload_byte expected %0h actual %0h", $time,
                         exp.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.last_of_frame !== exp.last_of_frame) begin
                $display("%0t: last_of_frame expected %0d actual %0d", $time,
                         exp.last_of_frame, got.last_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;
    logic      quiet = 1'b0;
    int        stall_cycles = 0;

    deframer_scoreboard sb;
    t_in_beat           seq_q[$];
    bit                 need_start;

    length_prefix_frame_deframer #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_beat)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.record_byte(in_beat);
        if (rst_n && out_valid && out_ready) sb.compare_result(out_beat);
    end

    always @(posedge clk) begin
        if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_beat(t_in_beat b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    task automatic add_beat(logic [7:0] data, bit start);
        t_in_beat b;
        b.data_byte = data;
        b.body_start = start;
        seq_q.push_back(b);
    endtask

    task automatic add_digits(string s);
        for (int i = 0; i < s.len(); i++) add_beat(s[i] - CHAR_ZERO, 1'b0);
    endtask

    task automatic add_frame(string s, int n_payload, bit start);
        add_beat(MARKER_BYTE, start);
        add_digits(s);
        add_beat(TERM_BYTE, 1'b0);
        for (int i = 0; i < n_payload; i++) add_beat(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic add_noise(int n);
        for (int i = 0; i < n; i++) begin
            add_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
    endtask

    task automatic send_queued(int keep);
        for (int i = 0; i < keep; i++) send_beat(seq_q[i]);
        seq_q.delete();
    endtask

    function automatic string pad_num(logic [63:0] v, int width);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < width) s = {"0", s};
        return s;
    endfunction

    initial begin
        int          pick;
        int          len;
        int          wid;
        bit          start;
        bit          held;
        string       s;
        sb = new();
        held = 0;
        need_start = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_frame("0", 0, 1'b1);
        add_beat(MARKER_BYTE, 1'b0);
        add_beat(8'd2, 1'b0);
        add_beat(TERM_BYTE, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h05, 1'b0);
        add_beat(TERM_BYTE, 1'b0);
        add_beat(MARKER_BYTE, 1'b1);
        add_beat(8'd10, 1'b0);
        add_beat(MARKER_BYTE, 1'b1);
        add_beat(TERM_BYTE, 1'b0);
        add_frame("3", 1, 1'b1);
        add_frame("1", 1, 1'b1);
        send_queued(seq_q.size());

        while (sb.live_beats < RUN_BEATS) begin
            quiet <= (sb.live_beats >= 300 && sb.live_beats < 550);
            if (!held && sb.live_beats >= 900) begin
                held = 1;
                in_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            pick = $urandom_range(99);
            start = need_start || ($urandom_range(7) == 0);
            need_start = 0;
            if (pick < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
                wid = ($urandom_range(15) == 0) ? MAX_DIGITS : $urandom_range(1, 4);
                add_frame(pad_num(64'(len), wid), len, start);
                send_queued(seq_q.size());
            end else if (pick < 65) begin
                len = $urandom_range(1, 20);
                add_frame(pad_num(64'(len), $urandom_range(1, 3)), len, start);
                send_queued($urandom_range(1, seq_q.size() - 1));
                need_start = 1;
            end else if (pick < 72) begin
                add_frame(pad_num(64'($urandom_range(0, 99)), MAX_DIGITS + 1), 0, start);
                add_noise($urandom_range(0, 4));
                send_queued(seq_q.size());
                need_start = 1;
            end else if (pick < 78) begin
                case ($urandom_range(3))
                    0: s = "99999999999999999999";
                    1: s = {"1844674407370955161", $sformatf("%0d", $urandom_range(5, 9))};
                    2: s = "18446744073709551615";
                    default: s = {$sformatf("%0d", $urandom_range(1, 9)),
                                  pad_num({$urandom, $urandom} % 64'd10000000000000000000,
                                          19)};
                endcase
                add_frame(s, $urandom_range(0, 3), start);
                send_queued(seq_q.size());
                need_start = 1;
            end else if (pick < 85) begin
                add_beat(MARKER_BYTE, start);
                add_digits(pad_num(64'($urandom_range(0, 999)), $urandom_range(0, 3)));
                add_beat(8'($urandom_range(10, 254)), 1'b0);
                add_noise($urandom_range(0, 3));
                send_queued(seq_q.size());
                need_start = 1;
            end else if (pick < 90) begin
                add_beat(MARKER_BYTE, start);
                add_beat(TERM_BYTE, 1'b0);
                send_queued(seq_q.size());
                need_start = 1;
            end else if (pick < 95) begin
                add_beat(8'($urandom_range(1, 255)), start);
                add_noise($urandom_range(0, 3));
                send_queued(seq_q.size());
                need_start = 1;
            end else begin
                add_noise($urandom_range(1, 8));
                send_queued(seq_q.size());
                need_start = 1;
            end
        end

        in_valid <= 1'b0;
        quiet <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
